### hdl/oat_pkg.sv
// shared types and codes for the ordered array table
// no dependencies

package oat_pkg;

	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR   = 3'd0,
		FN_INSERT  = 3'd1,
		FN_DELETE  = 3'd2,
		FN_SEARCH  = 3'd3,
		FN_DISPLAY = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic imm;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic scan_need;
		logic last_step;
		logic is_display;
	} stat_t;

endpackage

### hdl/oat_ctrl.sv
// controller state machine for the ordered array table
// depends on oat_pkg

module oat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  oat_pkg::stat_t stat,
	output oat_pkg::cmd_t  cmd
);

	oat_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oat_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oat_pkg::FSM_IDLE: begin
				if (in_valid && stat.out_free && stat.scan_need) begin
					state_d = oat_pkg::FSM_SCAN;
				end
			end
			oat_pkg::FSM_SCAN: begin
				if (stat.out_free && stat.last_step) begin
					state_d = stat.is_display ? oat_pkg::FSM_IDLE : oat_pkg::FSM_FINISH;
				end
			end
			oat_pkg::FSM_FINISH: begin
				if (stat.out_free) begin
					state_d = oat_pkg::FSM_IDLE;
				end
			end
			default: state_d = oat_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			oat_pkg::FSM_IDLE: begin
				in_stall = !stat.out_free;
				if (in_valid && stat.out_free) begin
					cmd.take = stat.scan_need;
					cmd.imm  = !stat.scan_need;
				end
			end
			oat_pkg::FSM_SCAN:   cmd.step   = stat.out_free;
			oat_pkg::FSM_FINISH: cmd.finish = stat.out_free;
			default: ;
		endcase
	end

endmodule

### hdl/oat_cells.sv
// datapath: row of shifting cells, fill count, scan counter and result register
// depends on oat_pkg

module oat_cells #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [oat_pkg::FUNC_W-1:0]          func,
	input  logic signed [oat_pkg::DATA_W-1:0]   value,
	input  logic [oat_pkg::POS_W-1:0]           position,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [oat_pkg::STAT_W-1:0]          status,
	output logic signed [oat_pkg::DATA_W-1:0]   data_out,
	output logic [oat_pkg::POS_W-1:0]           index_out,
	output logic                                last,
	input  oat_pkg::cmd_t                       cmd,
	output oat_pkg::stat_t                      stat
);

	localparam int PW = oat_pkg::POS_W;
	localparam int DW = oat_pkg::DATA_W;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [DW-1:0]   cell_q [DEPTH];
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   scan_q;
	logic [IW-1:0]   pend_q;
	logic            pend_v_q;
	logic [DW-1:0]   gone_q;
	oat_pkg::func_t  op_q;
	logic [DW-1:0]   value_q;
	logic [PW-1:0]   pos_q;

	logic            out_valid_q;
	oat_pkg::status_t status_q;
	logic [DW-1:0]   data_q;
	logic [PW-1:0]   index_q;
	logic            last_q;

	oat_pkg::func_t  fn;
	logic [PW-1:0]   count_w;
	logic            is_full;
	logic            is_empty;
	logic            ins_ok;
	logic            match;
	logic            last_step;

	assign fn        = oat_pkg::func_t'(func);
	assign count_w   = PW'(count_q);
	assign is_full   = count_q == CW'(DEPTH);
	assign is_empty  = count_q == '0;
	assign ins_ok    = !is_full && !(position > count_w);
	assign match     = cell_q[0] == value_q;
	assign last_step = CW'(scan_q) == count_q - CW'(1);

	always_comb begin
		stat.out_free   = !out_valid_q || !out_stall;
		stat.last_step  = last_step;
		stat.is_display = op_q == oat_pkg::FN_DISPLAY;
		stat.scan_need  = 1'b0;
		case (fn)
			oat_pkg::FN_SEARCH, oat_pkg::FN_DISPLAY: stat.scan_need = !is_empty;
			oat_pkg::FN_DELETE: stat.scan_need = !is_empty && position < count_w;
			default: stat.scan_need = 1'b0;
		endcase
	end

	// immediate result for ops that finish on acceptance
	oat_pkg::status_t imm_status;
	always_comb begin
		unique case (fn)
			oat_pkg::FN_CLEAR:  imm_status = oat_pkg::ST_OK;
			oat_pkg::FN_INSERT: imm_status = is_full ? oat_pkg::ST_OVERFLOW :
				(ins_ok ? oat_pkg::ST_OK : oat_pkg::ST_BADPOS);
			oat_pkg::FN_DELETE: imm_status = is_empty ? oat_pkg::ST_EMPTY : oat_pkg::ST_BADPOS;
			oat_pkg::FN_SEARCH, oat_pkg::FN_DISPLAY: imm_status = oat_pkg::ST_EMPTY;
			default:            imm_status = oat_pkg::ST_OK;
		endcase
	end

	logic do_insert;
	assign do_insert = cmd.imm && fn == oat_pkg::FN_INSERT && ins_ok;

	// cells: insert shifts up, delete shifts down, scan rotates the used part
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] below;
		logic [DW-1:0] above;
		logic [PW-1:0] idx;
		assign idx = PW'(i);
		if (i == 0) begin : g_first
			assign below = cell_q[i];
		end else begin : g_mid
			assign below = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign above = cell_q[i];
		end else begin : g_low
			assign above = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (idx == position) begin
					cell_q[i] <= value;
				end else if (idx > position && idx <= count_w) begin
					cell_q[i] <= below;
				end
			end else if (cmd.step) begin
				if (idx == count_w - PW'(1)) begin
					cell_q[i] <= cell_q[0];
				end else if (idx < count_w) begin
					cell_q[i] <= above;
				end
			end else if (cmd.finish && op_q == oat_pkg::FN_DELETE) begin
				if (idx >= pos_q && idx < count_w - PW'(1)) begin
					cell_q[i] <= above;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			scan_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.imm && fn == oat_pkg::FN_CLEAR) begin
				count_q <= '0;
			end else if (do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.finish && op_q == oat_pkg::FN_DELETE) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.take) begin
				scan_q   <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.step) begin
				scan_q <= scan_q + IW'(1);
				if (op_q == oat_pkg::FN_SEARCH && match) begin
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= fn;
			value_q <= value;
			pos_q   <= position;
		end
		if (cmd.step) begin
			if (op_q == oat_pkg::FN_SEARCH && match) begin
				pend_q <= scan_q;
			end
			if (PW'(scan_q) == pos_q) begin
				gone_q <= cell_q[0];
			end
		end
	end

	// result register
	logic             emit;
	oat_pkg::status_t res_status;
	logic [DW-1:0]    res_data;
	logic [PW-1:0]    res_index;
	logic             res_last;

	always_comb begin
		emit       = 1'b0;
		res_status = oat_pkg::ST_OK;
		res_data   = '0;
		res_index  = '0;
		res_last   = 1'b1;
		if (cmd.imm) begin
			emit       = 1'b1;
			res_status = imm_status;
		end else if (cmd.step) begin
			if (op_q == oat_pkg::FN_DISPLAY) begin
				emit      = 1'b1;
				res_data  = cell_q[0];
				res_index = PW'(scan_q);
				res_last  = last_step;
			end else if (op_q == oat_pkg::FN_SEARCH && match && pend_v_q) begin
				// earlier match goes out once a later one is known
				emit      = 1'b1;
				res_index = PW'(pend_q);
				res_last  = 1'b0;
			end
		end else if (cmd.finish) begin
			emit = 1'b1;
			if (op_q == oat_pkg::FN_DELETE) begin
				res_data = gone_q;
			end else if (pend_v_q) begin
				res_index = PW'(pend_q);
			end else begin
				res_status = oat_pkg::ST_NOTFOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= res_status;
			data_q   <= res_data;
			index_q  <= res_index;
			last_q   <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign index_out = index_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> CW'(scan_q) < count_q)
		else $error("scan step past fill count");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.imm && !cmd.finish) |=> count_q == $past(count_q))
		else $error("fill count changed without a request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result overwritten while stalled");

endmodule

### hdl/ordered_array_table.sv
// top level of the ordered array table
// depends on oat_pkg, oat_ctrl, oat_cells

// Ordered table of up to DEPTH signed 32-bit words with a fill count. Each
// request is clear, insert, delete, search or display. Clear, insert and every
// error case finish in the cycle the request is taken, the cells shifting up
// in one step. Search, display and a valid delete walk the used entries, at
// most DEPTH, by rotating the cell row one place a cycle (held while the
// output is stalled) and reading cell zero; search and delete then take a
// finishing state that display skips. Search and display give one result per
// match or word, a search with no match giving one not-found result; the
// final result of each request has last set. No clearing pass follows reset.

module ordered_array_table #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [oat_pkg::FUNC_W-1:0]        func,
	input  logic signed [oat_pkg::DATA_W-1:0] value,
	input  logic [oat_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [oat_pkg::STAT_W-1:0]        status,
	output logic signed [oat_pkg::DATA_W-1:0] data_out,
	output logic [oat_pkg::POS_W-1:0]         index_out,
	output logic                              last
);

	oat_pkg::cmd_t  cmd;
	oat_pkg::stat_t stat;

	oat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	oat_cells #(
		.DEPTH (DEPTH)
	) u_cells (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.value     (value),
		.position  (position),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.data_out  (data_out),
		.index_out (index_out),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
